// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by radix_constant_parser.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/rcp_pkg.sv =====
// Types, codes and helpers of the radix constant parser.
`default_nettype none
package rcp_pkg;

    typedef enum logic [2:0] {
        FUNC_DEC   = 3'd0,
        FUNC_HEX   = 3'd1,
        FUNC_OCT   = 3'd2,
        FUNC_BIN   = 3'd3,
        FUNC_QUOTE = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_DIGIT = 3'd1,
        ERR_OVERFLOW  = 3'd2,
        ERR_BAD_ESC   = 3'd3,
        ERR_SYNTAX    = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        QPH_OPEN   = 2'd0,
        QPH_INSIDE = 2'd1,
        QPH_ESCAPE = 2'd2,
        QPH_CLOSED = 2'd3
    } t_qph;

    localparam int unsigned ValueW = 32;

    localparam logic [ValueW-1:0] HexLimit  = 32'h0fff_ffff;
    localparam logic [ValueW-1:0] OctLimit  = 32'h1fff_ffff;
    localparam logic [ValueW-1:0] BinLimit  = 32'h7fff_ffff;
    localparam logic [ValueW-1:0] CharLimit = 32'h00ff_ffff;

    localparam logic [7:0] ChBackslash = 8'h5c;
    localparam logic [7:0] ChDquote    = 8'h22;
    localparam logic [7:0] ChSquote    = 8'h27;
    localparam logic [7:0] ChLowT      = 8'h74;
    localparam logic [7:0] ChLowN      = 8'h6e;
    localparam logic [7:0] ChLowR      = 8'h72;
    localparam logic [7:0] ChZero      = 8'h30;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] ch;
        logic       first;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic [2:0]        error;
        logic              done_res;
    } t_out_word;

    typedef struct packed {
        logic [ValueW-1:0] acc;
        t_err              err;
        logic [7:0]        delim;
        t_qph              phase;
    } t_state;

    // {is_hex_digit, digit value}
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/radix_constant_parser.sv =====
// Top level of the radix constant parser: input register, step logic, result register.
//
// Usage: one character of a numeric literal per input word on the in channel
// (func selects decimal, hex, octal, binary or quoted character; first starts
// a new literal, last ends its text). Every input word yields exactly one
// output word with the running 32-bit value, the sticky error code and
// done_res, which copies last.
// Both channels use valid/stall: a word moves on a rising edge with valid high
// and stall low.
// A word accepted on the in channel is held in the input register, stepped
// through the parser logic and registered in the result register for the out channel.
// Throughput: one word per cycle while the receiver does not stall, set by the
// step from the input register to the result register that also holds the parser state.
// Stall from the receiver freezes the result register and the input register;
// the in channel stalls only when both are full.
// Reset (synchronous, active low) empties both registers and clears the
// accumulator, error code, delimiter and quote phase.
`default_nettype none
`include "assert_macros.svh"
module radix_constant_parser (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  rcp_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output rcp_pkg::t_out_word  o_out_word
);
    import rcp_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_state    r_st;
    t_state    n_st;
    logic      adv;
    logic      in_acc;

    rcp_step u_step (
        .i_word (r_in_word),
        .i_st   (r_st),
        .o_st   (n_st)
    );

    // step fires when the input register holds a word and the result slot frees up
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_word <= i_in_word;
        end
        if (adv) begin
            r_out_word.value    <= n_st.acc;
            r_out_word.error    <= n_st.err;
            r_out_word.done_res <= r_in_word.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n,
        adv && !r_in_word.first && r_st.err != ERR_NONE, r_st.err == $past(r_st.err),
        "error code changed within a literal")
    `ASSERT_NEXT(a_out_matches_state, i_clk, i_rst_n,
        adv, o_out_word.value == r_st.acc && o_out_word.error == r_st.err,
        "result word does not match parser state")
    `ASSERT_NEXT(a_in_held, i_clk, i_rst_n,
        r_in_valid && !adv, r_in_valid && r_in_word == $past(r_in_word),
        "pending input word lost or overwritten")
    `ASSERT_NEXT(a_state_frozen, i_clk, i_rst_n,
        !adv, r_st == $past(r_st),
        "parser state changed without a step")

endmodule
`default_nettype wire

// ===== hw/rtl/rcp_step.sv =====
// Next-state logic for one character: digit accumulate, quote handling, errors.
`default_nettype none
module rcp_step (
    input  rcp_pkg::t_in_word i_word,
    input  rcp_pkg::t_state   i_st,
    output rcp_pkg::t_state   o_st
);
    import rcp_pkg::*;

    t_state            st;
    logic [4:0]        dg;
    logic              dg_ok;
    logic [3:0]        dv;
    logic [35:0]       dec_sum;
    logic [ValueW-1:0] acc_nx;
    t_err              err_nx;
    t_qph              ph_nx;
    logic [7:0]        delim_nx;
    t_err              fault;
    logic              do_shift;
    logic [7:0]        shift_ch;

    always_comb begin
        st       = i_word.first ? '0 : i_st;
        dg       = digit_of(i_word.ch);
        dv       = dg[3:0];
        dec_sum  = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0} + {32'd0, dv};
        acc_nx   = st.acc;
        ph_nx    = st.phase;
        delim_nx = st.delim;
        fault    = ERR_NONE;
        do_shift = 1'b0;
        shift_ch = i_word.ch;
        dg_ok    = 1'b0;

        case (i_word.func)
            FUNC_DEC: begin
                dg_ok = dg[4] && (dv < 4'd10);
                if (!dg_ok) begin
                    fault = ERR_BAD_DIGIT;
                end else begin
                    if (dec_sum[35:32] != 4'd0) fault = ERR_OVERFLOW;
                    acc_nx = dec_sum[31:0];
                end
            end
            FUNC_HEX: begin
                if (!dg[4]) begin
                    fault = ERR_BAD_DIGIT;
                end else begin
                    if (st.acc > HexLimit) fault = ERR_OVERFLOW;
                    acc_nx = {st.acc[27:0], dv};
                end
            end
            FUNC_OCT: begin
                dg_ok = dg[4] && (dv < 4'd8);
                if (!dg_ok) begin
                    fault = ERR_BAD_DIGIT;
                end else begin
                    if (st.acc > OctLimit) fault = ERR_OVERFLOW;
                    acc_nx = {st.acc[28:0], dv[2:0]};
                end
            end
            FUNC_BIN: begin
                dg_ok = dg[4] && (dv < 4'd2);
                if (!dg_ok) begin
                    fault = ERR_BAD_DIGIT;
                end else begin
                    if (st.acc > BinLimit) fault = ERR_OVERFLOW;
                    acc_nx = {st.acc[30:0], dv[0]};
                end
            end
            FUNC_QUOTE: begin
                case (st.phase)
                    QPH_OPEN: begin
                        delim_nx = i_word.ch;
                        ph_nx    = QPH_INSIDE;
                    end
                    QPH_INSIDE: begin
                        if (i_word.ch == st.delim) begin
                            ph_nx = QPH_CLOSED;
                        end else if (i_word.ch < 8'h20 || i_word.ch > 8'h7e) begin
                            fault = ERR_BAD_DIGIT;
                        end else if (i_word.ch == ChBackslash) begin
                            ph_nx = QPH_ESCAPE;
                        end else begin
                            do_shift = 1'b1;
                        end
                    end
                    QPH_ESCAPE: begin
                        ph_nx    = QPH_INSIDE;
                        do_shift = 1'b1;
                        case (i_word.ch)
                            ChLowT:      shift_ch = 8'h09;
                            ChLowN:      shift_ch = 8'h0a;
                            ChLowR:      shift_ch = 8'h0d;
                            ChZero:      shift_ch = 8'h00;
                            ChDquote,
                            ChSquote,
                            ChBackslash: shift_ch = i_word.ch;
                            default: begin
                                do_shift = 1'b0;
                                fault    = ERR_BAD_ESC;
                            end
                        endcase
                    end
                    default: fault = ERR_SYNTAX;
                endcase
                if (do_shift) begin
                    if (st.acc > CharLimit) fault = ERR_OVERFLOW;
                    acc_nx = {st.acc[23:0], shift_ch};
                end
                // unterminated quote at end of text
                if (i_word.last && ph_nx != QPH_CLOSED && fault == ERR_NONE) begin
                    fault = ERR_SYNTAX;
                end
            end
            default: fault = ERR_BAD_DIGIT;
        endcase

        err_nx = (st.err == ERR_NONE) ? fault : st.err;

        o_st.acc   = acc_nx;
        o_st.err   = err_nx;
        o_st.delim = delim_nx;
        o_st.phase = ph_nx;
    end

endmodule
`default_nettype wire
